### src/gdrf_pkg.sv
package gdrf_pkg;

  localparam int CacheEntriesDef = 32;

  localparam logic [31:0] ImmunityRst = 32'd500;
  localparam logic [7:0]  MaxEchoesRst = 8'd3;
  localparam logic [6:0]  ProbBaseRst = 7'd100;
  localparam logic [6:0]  ProbDecayRst = 7'd50;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegImmunity = 2'd0;
  localparam logic [1:0] RegMaxEchoes = 2'd1;
  localparam logic [1:0] RegProbBase = 2'd2;
  localparam logic [1:0] RegProbDecay = 2'd3;

  // Request codes.
  localparam logic ReqRecord = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // One cache entry as it moves through the row of cells.
  typedef struct packed {
    logic        valid;
    logic [31:0] hash;
    logic [31:0] tstamp;
    logic [7:0]  count;
    logic        relayed;
  } entry_t;

  // Write-back command broadcast from the controller to every cell.
  typedef struct packed {
    logic        wr;
    logic [31:0] hash;
    logic [31:0] tstamp;
    logic [7:0]  count;
    logic        relayed;
  } wb_t;

endpackage

### src/gdrf_cell.sv
// One cache slot. It compares its entry with the word hash broadcast to every
// cell, and hands the search result to its right-hand neighbor.
module gdrf_cell import gdrf_pkg::*; #(
  parameter int IdxW = 5,
  parameter logic [IdxW-1:0] MyIdx = '0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [31:0]     key,
  input  logic            found_in,
  input  logic [IdxW-1:0] idx_in,
  input  entry_t          ent_in,
  input  wb_t             wb,
  input  logic [IdxW-1:0] wb_idx,
  output logic            found_out,
  output logic [IdxW-1:0] idx_out,
  output entry_t          ent_out
);

  entry_t ent_r;
  logic   match;

  // Valid bit needs a reset; payload does not, but is kept in one struct.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else if (wb.wr && wb_idx == MyIdx) begin
      ent_r <= '{valid: 1'b1, hash: wb.hash, tstamp: wb.tstamp,
                 count: wb.count, relayed: wb.relayed};
    end
  end

  // Lowest matching index wins: a find upstream passes through unchanged.
  assign match     = ent_r.valid && ent_r.hash == key;
  assign found_out = found_in || match;
  assign idx_out   = found_in ? idx_in : MyIdx;
  assign ent_out   = found_in ? ent_in : ent_r;

endmodule

### src/gossip_duplicate_relay_filter_core.sv
// Gossip duplicate filter with a row of cache cells. A word is hashed in three
// registered multiply-add steps, then searched combinationally along the cell
// row with the search result registered, then decided. A record, a miss or a
// refused query goes from the decision straight to the output state. A query
// that reaches the relay draw first passes through one decay multiply per
// step. There are up to count-1 of them (at most max_echoes-2), and fewer
// once the probability reaches zero. The next word can be accepted once the
// result is registered. A result register holds the answer while it waits on
// out_stall, and a new result waits only while the previous one is still
// unaccepted.
module gossip_duplicate_relay_filter_core import gdrf_pkg::*; #(
  parameter int CacheEntries = CacheEntriesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [31:0] in_node_id,
  input  logic [31:0] in_seq_num,
  input  logic [7:0]  in_msg_type,
  input  logic [15:0] in_payload_lo,
  input  logic [31:0] in_now_tick,
  input  logic [31:0] in_rand_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_relay,
  output logic        out_hit,
  output logic        out_dropped,
  output logic [31:0] out_drop_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StHash   = 3'd1;
  localparam logic [2:0] StSearch = 3'd2;
  localparam logic [2:0] StDecide = 3'd3;
  localparam logic [2:0] StDecay  = 3'd4;
  localparam logic [2:0] StDraw   = 3'd5;
  localparam logic [2:0] StOut    = 3'd6;

  // Configuration registers.
  logic [31:0] immunity_r;
  logic [7:0]  max_echoes_r;
  logic [6:0]  prob_base_r, prob_decay_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      immunity_r   <= ImmunityRst;
      max_echoes_r <= MaxEchoesRst;
      prob_base_r  <= ProbBaseRst;
      prob_decay_r <= ProbDecayRst;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        RegImmunity:  immunity_r   <= pwdata;
        RegMaxEchoes: max_echoes_r <= pwdata[7:0];
        RegProbBase:  prob_base_r  <= pwdata[6:0];
        RegProbDecay: prob_decay_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegImmunity:  prdata = immunity_r;
      RegMaxEchoes: prdata = {24'd0, max_echoes_r};
      RegProbBase:  prdata = {25'd0, prob_base_r};
      RegProbDecay: prdata = {25'd0, prob_decay_r};
      default:      prdata = '0;
    endcase
  end

  // Controller registers.
  logic [2:0]      state_r, state_nxt;
  logic [1:0]      step_r;
  logic            req_r;
  logic [31:0]     h_r, seq_r, now_r, rnd_r;
  logic [7:0]      typ_r;
  logic [15:0]     pay_r;
  logic            found_r;
  logic [IdxW-1:0] idx_r;
  entry_t          ent_r;
  logic [IdxW-1:0] wptr_r;
  logic [31:0]     drop_r;
  logic [13:0]     p_r;
  logic [7:0]      j_r;
  logic [6:0]      rmod_r;
  logic [26:0]     q_r;
  logic            res_relay_r, res_hit_r, res_drop_r;
  logic            o_valid_r, o_relay_r, o_hit_r, o_drop_r;
  logic [31:0]     o_drops_r;

  // Search row.
  logic            found_c [CacheEntries+1];
  logic [IdxW-1:0] idx_c   [CacheEntries+1];
  entry_t          ent_c   [CacheEntries+1];
  wb_t             wb;
  logic [IdxW-1:0] wb_idx;

  assign found_c[0] = 1'b0;
  assign idx_c[0]   = '0;
  assign ent_c[0]   = '0;

  for (genvar g = 0; g < CacheEntries; g++) begin : g_cell
    gdrf_cell #(.IdxW(IdxW), .MyIdx(IdxW'(g))) u_cell (
      .clk, .rst_n, .key(h_r), .found_in(found_c[g]), .idx_in(idx_c[g]),
      .ent_in(ent_c[g]), .wb, .wb_idx, .found_out(found_c[g+1]),
      .idx_out(idx_c[g+1]), .ent_out(ent_c[g+1])
    );
  end

  logic        take;
  logic [31:0] hstep_in;
  logic [31:0] age;
  logic        stale;
  logic [7:0]  cnt_eff;
  logic [6:0]  keep;
  logic [13:0] prod;
  logic [63:0] qprod;
  logic [31:0] rem_full;

  assign in_stall = state_r != StIdle;
  assign take     = in_valid && !in_stall;
  assign out_valid      = o_valid_r;
  assign out_relay      = o_relay_r;
  assign out_hit        = o_hit_r;
  assign out_dropped    = o_drop_r;
  assign out_drop_total = o_drops_r;

  always_comb begin
    case (step_r)
      2'd0:    hstep_in = seq_r;
      2'd1:    hstep_in = {24'd0, typ_r};
      default: hstep_in = {16'd0, pay_r};
    endcase
  end

  // The random word modulo 100, by reciprocal multiply over the hash cycles.
  assign qprod    = {32'd0, rnd_r} * 64'h0000_0000_51EB_851F;
  assign rem_full = rnd_r - ({5'd0, q_r} * 32'd100);

  assign age     = now_r - ent_r.tstamp;
  assign stale   = age > immunity_r;
  assign cnt_eff = stale ? 8'd1 : ent_r.count;
  assign keep    = (prob_decay_r > 7'd100) ? 7'd0 : 7'd100 - prob_decay_r;
  // p*keep is at most 127*100; divide by 100 by reciprocal 5243>>19.
  assign prod    = 14'((p_r[6:0] * keep) * 28'd5243 >> 19);

  // Write-back into the row, issued at the decision or the draw.
  always_comb begin
    wb     = '0;
    wb_idx = found_r ? idx_r : wptr_r;
    if (state_r == StDecide && req_r == ReqRecord) begin
      wb.wr = 1'b1;
      if (found_r) begin
        wb.hash = ent_r.hash; wb.tstamp = ent_r.tstamp; wb.relayed = ent_r.relayed;
        wb.count = (ent_r.count == 8'hFF) ? 8'hFF : ent_r.count + 8'd1;
      end else begin
        wb.hash = h_r; wb.tstamp = now_r; wb.count = 8'd1; wb.relayed = 1'b0;
      end
    end else if (state_r == StDecide && found_r && stale) begin
      wb.wr = 1'b1; wb.hash = ent_r.hash; wb.tstamp = now_r;
      wb.count = 8'd1; wb.relayed = ent_r.relayed;
    end else if (state_r == StDraw && {7'd0, rmod_r} < p_r) begin
      wb.wr = 1'b1; wb.hash = ent_r.hash; wb.relayed = 1'b1;
      wb.tstamp = stale ? now_r : ent_r.tstamp; wb.count = cnt_eff;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      StIdle:   if (take) state_nxt = StHash;
      StHash:   if (step_r == 2'd2) state_nxt = StSearch;
      StSearch: state_nxt = StDecide;
      StDecide: begin
        if (req_r == ReqRecord || !found_r || ent_r.relayed ||
            cnt_eff >= max_echoes_r) state_nxt = StOut;
        else state_nxt = StDecay;
      end
      StDecay:  if (j_r >= cnt_eff || p_r == '0) state_nxt = StDraw;
      StDraw:   state_nxt = StOut;
      StOut:    if (!o_valid_r || !out_stall) state_nxt = StIdle;
      default:  state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle; wptr_r <= '0; drop_r <= '0; o_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == StOut && state_nxt == StIdle) o_valid_r <= 1'b1;
      else if (!out_stall) o_valid_r <= 1'b0;
      if (state_r == StDecide && req_r == ReqRecord && !found_r)
        wptr_r <= (wptr_r == IdxW'(CacheEntries - 1)) ? '0 : wptr_r + 1'b1;
      if (state_r == StDecide && req_r == ReqQuery && found_r && !ent_r.relayed &&
          cnt_eff >= max_echoes_r) drop_r <= drop_r + 32'd1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_req_type; h_r <= in_node_id; seq_r <= in_seq_num;
      typ_r <= in_msg_type; pay_r <= in_payload_lo; now_r <= in_now_tick;
      rnd_r <= in_rand_value; step_r <= 2'd0;
    end
    case (state_r)
      StHash: begin
        h_r    <= (h_r << 5) - h_r + hstep_in;
        step_r <= step_r + 2'd1;
        q_r    <= qprod[63:37];
        rmod_r <= rem_full[6:0];
      end
      StSearch: begin
        found_r <= found_c[CacheEntries];
        idx_r   <= idx_c[CacheEntries];
        ent_r   <= ent_c[CacheEntries];
      end
      StDecide: begin
        res_relay_r <= req_r == ReqQuery && !found_r;
        res_hit_r   <= found_r;
        res_drop_r  <= req_r == ReqQuery && found_r && !ent_r.relayed &&
                       cnt_eff >= max_echoes_r;
        p_r <= {7'd0, prob_base_r};
        j_r <= 8'd1;
      end
      StDecay: if (!(j_r >= cnt_eff || p_r == '0)) begin
        p_r <= prod;
        j_r <= j_r + 8'd1;
      end
      StDraw: res_relay_r <= {7'd0, rmod_r} < p_r;
      StOut: if (state_nxt == StIdle) begin
        o_relay_r <= res_relay_r;
        o_hit_r   <= res_hit_r;
        o_drop_r  <= res_drop_r;
        o_drops_r <= drop_r;
      end
      default: ;
    endcase
  end

  // A result is only raised on leaving the output state.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(o_valid_r) |-> $past(state_r) == StOut) else $error("early result");
  a_drop_once: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r != $past(drop_r) |-> $past(state_r) == StDecide) else $error("drop count");
  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    o_drop_r && o_valid_r |-> !o_relay_r) else $error("drop and relay");

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top import gdrf_pkg::*; ;

  localparam int NumEntries = CacheEntriesDef;
  localparam int CycleLimit = 400000;

  // One packet word on the input side.
  typedef struct packed {
    logic        req;
    logic [31:0] node;
    logic [31:0] seq;
    logic [7:0]  mtype;
    logic [15:0] pay;
    logic [31:0] now;
    logic [31:0] rnd;
  } pkt_t;

  // One decision word on the result side.
  typedef struct packed {
    logic        relay;
    logic        hit;
    logic        dropped;
    logic [31:0] drops;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic [31:0] in_node_id = '0;
  logic [31:0] in_seq_num = '0;
  logic [7:0]  in_msg_type = '0;
  logic [15:0] in_payload_lo = '0;
  logic [31:0] in_now_tick = '0;
  logic [31:0] in_rand_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_relay;
  logic        out_hit;
  logic        out_dropped;
  logic [31:0] out_drop_total;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the cache and the registers.
  logic [31:0] sh_hash [NumEntries];
  logic [31:0] sh_time [NumEntries];
  logic [7:0]  sh_count [NumEntries];
  logic        sh_relayed [NumEntries];
  logic        sh_valid [NumEntries];
  int          sh_wptr;
  logic [31:0] sh_drops;
  logic [31:0] immunity;
  logic [7:0]  echo_limit;
  logic [6:0]  base_pct;
  logic [6:0]  decay_pct;

  verdict_t    pending_verdicts[$];
  int          errors = 0;
  int          cycles = 0;
  bit          stall_on = 1'b1;

  gossip_duplicate_relay_filter_core u_top (.*);

  always #2 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout at %0t", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int short_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Receiver stalls, with quiet stretches.
  always @(posedge clk) begin
    if (stall_on && rst_n)
      out_stall <= ($urandom_range(0, 3) == 0) ||
                   ($urandom_range(0, 60) == 0 ? 1'b1 : 1'b0);
    else
      out_stall <= 1'b0;
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected word relay=%0d hit=%0d", $time, out_relay, out_hit);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (want.relay !== out_relay) begin
          $display("%0t: relay exp %0d got %0d", $time, want.relay, out_relay);
          errors++;
        end
        if (want.hit !== out_hit) begin
          $display("%0t: hit exp %0d got %0d", $time, want.hit, out_hit);
          errors++;
        end
        if (want.dropped !== out_dropped) begin
          $display("%0t: dropped exp %0d got %0d", $time, want.dropped, out_dropped);
          errors++;
        end
        if (want.drops !== out_drop_total) begin
          $display("%0t: drop_total exp %0d got %0d", $time, want.drops, out_drop_total);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] packet_hash(pkt_t p);
    logic [31:0] h;
    h = p.node;
    h = h * 32'd31 + p.seq;
    h = h * 32'd31 + {24'd0, p.mtype};
    h = h * 32'd31 + {16'd0, p.pay};
    return h;
  endfunction

  // Predict the decision for one packet and update the shadow cache.
  function automatic verdict_t predict_decision(pkt_t p);
    verdict_t v;
    logic [31:0] h;
    int idx;
    int prob;
    int dec;
    v = '0;
    h = packet_hash(p);
    idx = -1;
    for (int i = NumEntries - 1; i >= 0; i--)
      if (sh_valid[i] && sh_hash[i] == h) idx = i;
    if (p.req == ReqRecord) begin
      if (idx >= 0) begin
        v.hit = 1'b1;
        if (sh_count[idx] != 8'd255) sh_count[idx]++;
      end else begin
        sh_hash[sh_wptr] = h;
        sh_time[sh_wptr] = p.now;
        sh_count[sh_wptr] = 8'd1;
        sh_relayed[sh_wptr] = 1'b0;
        sh_valid[sh_wptr] = 1'b1;
        sh_wptr = (sh_wptr + 1) % NumEntries;
      end
    end else if (idx < 0) begin
      v.relay = 1'b1;
    end else begin
      v.hit = 1'b1;
      if (p.now - sh_time[idx] > immunity) begin
        sh_count[idx] = 8'd1;
        sh_time[idx] = p.now;
      end
      if (sh_relayed[idx]) begin
        v.relay = 1'b0;
      end else if (sh_count[idx] >= echo_limit) begin
        sh_drops++;
        v.dropped = 1'b1;
      end else begin
        prob = base_pct;
        dec = (decay_pct > 100) ? 100 : decay_pct;
        for (int j = 1; j < sh_count[idx] && prob > 0; j++)
          prob = (prob * (100 - dec)) / 100;
        if ((p.rnd % 100) < prob) begin
          sh_relayed[idx] = 1'b1;
          v.relay = 1'b1;
        end
      end
    end
    v.drops = sh_drops;
    return v;
  endfunction

  // Send one word, with a random gap first. Valid stays high between
  // back-to-back words; the block stalls right after each acceptance.
  task automatic send_word(pkt_t p);
    int gap;
    gap = short_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= p.req;
    in_node_id <= p.node;
    in_seq_num <= p.seq;
    in_msg_type <= p.mtype;
    in_payload_lo <= p.pay;
    in_now_tick <= p.now;
    in_rand_value <= p.rnd;
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(predict_decision(p));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Register write over the configuration port, only while idle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegImmunity: immunity = val;
      RegMaxEchoes: echo_limit = val[7:0];
      RegProbBase: base_pct = val[6:0];
      RegProbDecay: decay_pct = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] imm, logic [7:0] me, logic [6:0] pb, logic [6:0] pd);
    drain();
    write_reg(RegImmunity, imm);
    write_reg(RegMaxEchoes, {24'd0, me});
    write_reg(RegProbBase, {25'd0, pb});
    write_reg(RegProbDecay, {25'd0, pd});
  endtask

  function automatic pkt_t make_pkt(logic req, logic [31:0] node, logic [31:0] now);
    pkt_t p;
    p.req = req;
    p.node = node;
    p.seq = 32'd7;
    p.mtype = 8'h11;
    p.pay = 16'h2233;
    p.now = now;
    p.rnd = $urandom;
    return p;
  endfunction

  // Directed cases: field extremes, hits, echo limit, staleness, relay marking.
  task automatic test_directed();
    pkt_t p;
    p = '1; p.req = ReqQuery;
    send_word(p);
    p.req = ReqRecord;
    send_word(p);
    send_word(p);
    p.req = ReqQuery; p.rnd = 32'd0;
    send_word(p);
    p = '0;
    send_word(p);
    p.req = ReqQuery; p.rnd = 32'd99;
    send_word(p);
    send_word(p);
    send_word(make_pkt(ReqRecord, 32'd5, 32'd0));
    send_word(make_pkt(ReqRecord, 32'd5, 32'd0));
    send_word(make_pkt(ReqRecord, 32'd5, 32'd0));
    send_word(make_pkt(ReqQuery, 32'd5, 32'd10));
    send_word(make_pkt(ReqQuery, 32'd5, 32'd10));
    // Stale entry counts as new again.
    send_word(make_pkt(ReqQuery, 32'd5, 32'd2000));
    send_word(make_pkt(ReqQuery, 32'd5, 32'hFFFF_FFFF));
    // Wrap the write pointer.
    for (int i = 0; i < NumEntries + 2; i++)
      send_word(make_pkt(ReqRecord, 32'h100 + i, 32'd0));
  endtask

  // Saturate one entry's count.
  task automatic test_saturation();
    for (int i = 0; i < 260; i++)
      send_word(make_pkt(ReqRecord, 32'hABC, 32'd1));
    send_word(make_pkt(ReqQuery, 32'hABC, 32'd1));
  endtask

  // Random traffic over a small pool of packets so that hits are common.
  task automatic test_random(int n);
    pkt_t p;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 47);
      if ($urandom_range(0, 9) == 0) begin
        p.req = 1'($urandom_range(0, 1));
        p.node = $urandom;
        p.seq = $urandom;
        p.mtype = 8'($urandom);
        p.pay = 16'($urandom);
        p.now = $urandom;
        p.rnd = $urandom;
      end else begin
        p.req = 1'($urandom_range(0, 1));
        p.node = 32'hF000_0000 ^ k;
        p.seq = k * 32'h0101_0101;
        p.mtype = k[7:0];
        p.pay = 16'h8000 | k[15:0];
        p.now = (i < n / 2) ? $urandom_range(0, 1500) : $urandom;
        p.rnd = $urandom;
      end
      if (i == n / 3) stall_on = 1'b0;
      if (i == n / 2) stall_on = 1'b1;
      send_word(p);
    end
  endtask

  initial begin
    for (int i = 0; i < NumEntries; i++) begin
      sh_hash[i] = '0; sh_time[i] = '0; sh_count[i] = '0;
      sh_relayed[i] = 1'b0; sh_valid[i] = 1'b0;
    end
    sh_wptr = 0;
    sh_drops = '0;
    immunity = ImmunityRst;
    echo_limit = MaxEchoesRst;
    base_pct = ProbBaseRst;
    decay_pct = ProbDecayRst;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    set_regs(32'd0, 8'd255, 7'd0, 7'd0);
    test_directed();
    set_regs(32'hFFFF_FFFF, 8'd1, 7'd127, 7'd127);
    test_random(100);
    test_saturation();
    set_regs(32'd200, 8'd6, 7'd80, 7'd30);
    test_random(250);
    set_regs(32'd1000, 8'd12, 7'd100, 7'd100);
    test_random(150);
    set_regs(32'd600, 8'd4, 7'd100, 7'd50);
    test_random(240);

    drain();
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
